### rtl/oste_pkg.sv
package oste_pkg;

    localparam int SLOT_COUNT_DEF = 32;

    localparam int TIME_W  = 32;
    localparam int EVENT_W = 16;
    localparam int LIMIT_W = 15;
    localparam int SLOT_W  = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_ADD_FULL = 2'd1,
        KIND_FIRED    = 2'd2,
        KIND_DONE     = 2'd3
    } kind_t;

endpackage

### rtl/one_shot_timer_event_table.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------------
// input    | s_valid / s_ready  | s_command, s_now, s_gap, s_event_number
// result   | m_valid / m_ready  | m_kind, m_fired_event, m_slot_index, m_last_item
// config   | cfg_wr_en          | cfg_wr_data (event limit)
//
// One slot is examined per cycle while scanning, by a single compare unit reading the
// slot memory at one address; scanning pauses while a result waits for m_ready. An add
// stops at the first free slot or reports full; a tick visits all slots, then reports done.
// s_ready is high only while idle; each result waits in the output register for m_ready.
// Synchronous active-low reset empties all slots through per-slot valid flops
// and sets the event limit to 32767; no clearing pass is needed.
module one_shot_timer_event_table import oste_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [LIMIT_W-1:0]        cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_command,
    input  logic [TIME_W-1:0]         s_now,
    input  logic [TIME_W-1:0]         s_gap,
    input  logic signed [EVENT_W-1:0] s_event_number,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic signed [EVENT_W-1:0] m_fired_event,
    output logic [SLOT_W-1:0]         m_slot_index,
    output logic                      m_last_item
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t                      state_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        cmd_reg;
    logic [TIME_W-1:0]           now_reg;
    logic [TIME_W-1:0]           new_dl_reg;
    logic [EVENT_W-1:0]          ev_in_reg;
    logic [SLOT_COUNT-1:0]       valid_reg;
    logic [LIMIT_W-1:0]          limit_reg;
    logic                        end_reg;
    kind_t                       kind_reg;
    logic [EVENT_W-1:0]          fired_ev_reg;
    logic [SLOT_W-1:0]           slot_reg;
    logic                        last_reg;

    logic [TIME_W+EVENT_W-1:0]   slot_mem [SLOT_COUNT];
    logic [TIME_W-1:0]           rd_dl_reg;
    logic [EVENT_W-1:0]          rd_ev_reg;

    logic [TIME_W-1:0]           slot_dl;
    logic [EVENT_W-1:0]          slot_ev;
    logic                        ev_pos;
    logic                        live;
    logic                        fire;
    logic                        idx_last;
    logic [IDX_W-1:0]            idx_inc;
    logic [IDX_W-1:0]            rd_addr;
    logic                        mem_we;

    // an entry whose valid flop is clear reads as an empty slot
    assign slot_dl  = valid_reg[idx_reg] ? rd_dl_reg : '0;
    assign slot_ev  = valid_reg[idx_reg] ? rd_ev_reg : '0;
    assign ev_pos   = !slot_ev[EVENT_W-1] && (slot_ev != '0);
    assign live     = (slot_dl != '0) && ev_pos && (slot_ev[LIMIT_W-1:0] < limit_reg);
    assign fire     = (slot_dl != '0) && ev_pos && (now_reg > slot_dl);
    assign idx_last = (idx_reg == LAST_IDX);
    assign idx_inc  = idx_last ? '0 : idx_reg + 1'b1;
    // prefetch the slot that will be examined next
    assign rd_addr  = (state_reg == ST_IDLE) ? '0 : idx_inc;
    assign mem_we   = (state_reg == ST_SCAN) && (cmd_reg == CMD_ADD) && !live;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[idx_reg] <= {new_dl_reg, ev_in_reg};
        end
        {rd_dl_reg, rd_ev_reg} <= slot_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= s_command;
                        now_reg    <= s_now;
                        new_dl_reg <= s_now + s_gap;
                        ev_in_reg  <= s_event_number;
                        idx_reg    <= '0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (cmd_reg == CMD_ADD) begin
                        if (!live) begin
                            valid_reg[idx_reg] <= 1'b1;
                            kind_reg     <= KIND_ADD_OK;
                            fired_ev_reg <= '0;
                            slot_reg     <= SLOT_W'(idx_reg);
                            last_reg     <= 1'b1;
                            state_reg    <= ST_OUT;
                        end else if (idx_last) begin
                            kind_reg     <= KIND_ADD_FULL;
                            fired_ev_reg <= '0;
                            slot_reg     <= '0;
                            last_reg     <= 1'b1;
                            state_reg    <= ST_OUT;
                        end else begin
                            idx_reg <= idx_inc;
                        end
                    end else begin
                        if (fire) begin
                            valid_reg[idx_reg] <= 1'b0;
                            kind_reg     <= KIND_FIRED;
                            fired_ev_reg <= slot_ev;
                            slot_reg     <= SLOT_W'(idx_reg);
                            last_reg     <= 1'b0;
                            end_reg      <= idx_last;
                            state_reg    <= ST_OUT;
                        end else if (idx_last) begin
                            kind_reg     <= KIND_DONE;
                            fired_ev_reg <= '0;
                            slot_reg     <= '0;
                            last_reg     <= 1'b1;
                            state_reg    <= ST_OUT;
                        end else begin
                            idx_reg <= idx_inc;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else if (end_reg) begin
                            // fired on the final slot: follow with the done transaction
                            kind_reg     <= KIND_DONE;
                            fired_ev_reg <= '0;
                            slot_reg     <= '0;
                            last_reg     <= 1'b1;
                        end else begin
                            idx_reg   <= idx_inc;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_kind        = kind_reg;
    assign m_fired_event = fired_ev_reg;
    assign m_slot_index  = slot_reg;
    assign m_last_item   = last_reg;

endmodule

### rtl/oste_checker.sv
module oste_checker import oste_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [1:0]                m_kind,
    input logic signed [EVENT_W-1:0] m_fired_event,
    input logic [SLOT_W-1:0]         m_slot_index,
    input logic                      m_last_item
);

    // one transaction in flight: never take input while a result is offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    // add results and done close the transaction, fired results never do
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_item == (m_kind != KIND_FIRED)))
        else $error("last_item does not match result kind");

    // only a fired result carries an event number
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_FIRED) |-> (m_fired_event == '0))
        else $error("nonzero event on a non-fired result");

    // a closing result returns the block to accepting input once taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_item) |=> (s_ready && !m_valid))
        else $error("block not idle after final result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_slot_index)))
        else $error("stalled result changed");

endmodule

bind one_shot_timer_event_table oste_checker u_oste_checker (.*);
